// ===== rtl/dcem_pkg.sv =====
// ----------------------------------------------------------------------------
// dcem_pkg: shared constants and types for the elapsed-milliseconds counter
// Widths of the counter reading, the tick total and the divider, and the
// reciprocal used to turn the clock frequency into ticks per millisecond.
// ----------------------------------------------------------------------------
package dcem_pkg;

   localparam int CounterBits = 24;
   localparam int TotalBits   = 64;
   localparam int ClockBits   = 32;

   // Reset frequency of the clock that drives the down counter.
   localparam logic [ClockBits-1:0] ClockHzReset = 32'd16000000;

   // floor(x / 1000) == (x * RecipMult) >> RecipShift for every 32-bit x.
   localparam logic [ClockBits-1:0] RecipMult  = 32'd2199023256;
   localparam int                   RecipShift = 41;
   localparam int                   ProdBits   = 2 * ClockBits;
   localparam int                   PerMsBits  = ProdBits - RecipShift;

   // Restoring divider: one quotient bit per step.
   localparam int DivSteps   = TotalBits;
   localparam int StepBits   = $clog2(DivSteps);
   localparam int QueueDepth = 2;
   localparam int QPtrBits   = $clog2(QueueDepth);
   localparam int QCntBits   = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/dcem_front.sv =====
// ----------------------------------------------------------------------------
// dcem_front: reading intake and tick accumulation
// Takes counter readings, adds the elapsed ticks to the running total and
// pushes the updated total into the queue towards the divider.
// ----------------------------------------------------------------------------
module dcem_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dcem_pkg::CounterBits-1:0]    req_tdata,   // counter_sample
   input  logic                                req_tuser,   // counter_restart
   input  dcem_pkg::q_stat_type                q_stat,
   output logic                                push,
   output logic [dcem_pkg::TotalBits-1:0]      push_data
);

   logic [dcem_pkg::TotalBits-1:0]   total_ff, total_in;
   logic [dcem_pkg::CounterBits-1:0] last_ff, last_in;
   logic [dcem_pkg::CounterBits-1:0] delta;
   logic                             accept;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // The counter counts down, so elapsed ticks are baseline minus reading,
   // wrapping naturally at the counter width.
   assign delta = last_ff - req_tdata;

   always_comb begin
      total_in = total_ff;
      last_in  = last_ff;
      if (accept) begin
         last_in = req_tdata;
         if (!req_tuser) begin
            total_in = total_ff + dcem_pkg::TotalBits'(delta);
         end
      end
   end

   assign push      = accept;
   assign push_data = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         last_ff  <= '0;
      end else begin
         total_ff <= total_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== rtl/dcem_queue.sv =====
// ----------------------------------------------------------------------------
// dcem_queue: short queue of tick totals
// Lets the intake run ahead of the divider by a couple of readings.
// ----------------------------------------------------------------------------
module dcem_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic [dcem_pkg::TotalBits-1:0]      push_data,
   input  logic                                pop,
   output logic [dcem_pkg::TotalBits-1:0]      pop_data,
   output dcem_pkg::q_stat_type                q_stat
);

   logic [dcem_pkg::TotalBits-1:0] mem [dcem_pkg::QueueDepth];
   logic [dcem_pkg::QPtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dcem_pkg::QPtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dcem_pkg::QCntBits-1:0]  count_ff, count_in;

   assign q_stat.full  = (count_ff == dcem_pkg::QCntBits'(dcem_pkg::QueueDepth));
   assign q_stat.empty = (count_ff == '0);
   assign pop_data     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dcem_pkg::QPtrBits'(dcem_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dcem_pkg::QPtrBits'(dcem_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full || pop)
      else $error("queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue read while empty");
`endif

endmodule

// ===== rtl/dcem_div.sv =====
// ----------------------------------------------------------------------------
// dcem_div: ticks-to-milliseconds divider
// Holds the clock frequency register, derives ticks per millisecond and
// divides each tick total by it, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcem_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dcem_pkg::ClockBits-1:0]      csr_wr_data,
   input  dcem_pkg::q_stat_type                q_stat,
   input  logic [dcem_pkg::TotalBits-1:0]      pop_data,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dcem_pkg::TotalBits-1:0]      rsp_tdata
);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      DONE
   } state_type;

   state_type                        state_ff;
   logic [dcem_pkg::ClockBits-1:0]   clock_hz_ff;
   logic [dcem_pkg::ProdBits-1:0]    prod_ff;
   logic [dcem_pkg::PerMsBits-1:0]   per_ms;
   logic [dcem_pkg::TotalBits-1:0]   quo_ff;
   logic [dcem_pkg::PerMsBits-1:0]   rem_ff;
   logic [dcem_pkg::StepBits-1:0]    step_ff;
   logic                             rsp_valid_ff;
   logic [dcem_pkg::TotalBits-1:0]   rsp_data_ff;
   logic [dcem_pkg::PerMsBits:0]     shifted;
   logic [dcem_pkg::PerMsBits:0]     diff;
   logic                             ge;
   logic                             out_free;

   assign per_ms = prod_ff[dcem_pkg::ProdBits-1:dcem_pkg::RecipShift];

   // A zero divisor makes every trial subtraction succeed, so the quotient
   // comes out as all ones without any special handling.
   assign shifted = {rem_ff, quo_ff[dcem_pkg::TotalBits-1]};
   assign diff    = shifted - {1'b0, per_ms};
   assign ge      = (shifted >= {1'b0, per_ms});

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = (state_ff == IDLE) && !q_stat.empty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      prod_ff <= dcem_pkg::ProdBits'(clock_hz_ff) * dcem_pkg::ProdBits'(dcem_pkg::RecipMult);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= dcem_pkg::ClockHzReset;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         // In DONE the output register is either still held or reloaded below.
         if (rsp_valid_ff && rsp_tready && (state_ff != DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (!q_stat.empty) begin
                  quo_ff   <= pop_data;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= DIVIDE;
               end
            end
            DIVIDE: begin
               quo_ff  <= {quo_ff[dcem_pkg::TotalBits-2:0], ge};
               rem_ff  <= ge ? diff[dcem_pkg::PerMsBits-1:0] : shifted[dcem_pkg::PerMsBits-1:0];
               step_ff <= step_ff + 1'b1;
               if (step_ff == dcem_pkg::StepBits'(dcem_pkg::DivSteps - 1)) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (out_free) begin
                  rsp_data_ff  <= quo_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_pop_when_idle : assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == DIVIDE)
      else $error("divider did not start after taking a total");

   a_result_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DONE))
      else $error("result presented without a finished division");
`endif

endmodule

// ===== rtl/down_counter_elapsed_ms.sv =====
// ----------------------------------------------------------------------------
// down_counter_elapsed_ms: milliseconds elapsed from down-counter readings
// Accumulates elapsed ticks from successive readings of a free-running down
// counter and reports the total in milliseconds for every reading.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  req_      in         tdata: counter_sample [23:0]; tuser: counter_restart
//  rsp_      out        tdata: elapsed_ms [63:0]
//  csr_      in         csr_wr_data: clock_hz [31:0], written when csr_wr_en
//
// Each result passes the divider states in order: IDLE fetches a total from the
// queue, DIVIDE runs 64 restoring steps of one quotient bit each, and DONE hands
// the result to the output register; that divider sets the sustained rate.
// The intake accepts a reading per cycle until the two-entry queue fills.
// A stalled result waits in the output register while the queue keeps filling.
// Reset is synchronous; it clears the totals and loads clock_hz with 16 MHz.
// ----------------------------------------------------------------------------
module down_counter_elapsed_ms (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,   // [23:0] counter_sample
   input  logic                                req_tuser,   // [0] counter_restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,   // [63:0] elapsed_ms
   input  logic                                csr_wr_en,
   input  logic [31:0]                         csr_wr_data
);

   dcem_pkg::q_stat_type              q_stat;
   logic                              push;
   logic [dcem_pkg::TotalBits-1:0]    push_data;
   logic                              pop;
   logic [dcem_pkg::TotalBits-1:0]    pop_data;

   dcem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata[dcem_pkg::CounterBits-1:0]),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   dcem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   dcem_div u_div (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_stat      (q_stat),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
